// ===== src/mcpu_pkg.sv =====
// Package: shared types, constants and codes for the microcoded CPU clock step.
package mcpu_pkg;

  localparam int unsigned RamBytes    = 65536;
  localparam int unsigned FlashBytes  = 524288;
  localparam int unsigned SectorBytes = 4096;
  localparam int unsigned UcodeDepth  = 131072;

  // item kinds
  localparam logic [2:0] KindTick  = 3'd0;
  localparam logic [2:0] KindUcode = 3'd1;
  localparam logic [2:0] KindFlash = 3'd2;
  localparam logic [2:0] KindRam   = 3'd3;
  localparam logic [2:0] KindPs2   = 3'd4;
  localparam logic [2:0] KindUart  = 3'd5;
  localparam logic [2:0] KindWarm  = 3'd6;

  localparam logic [23:0] InvMask = 24'b001111110111111111111001;

  // control word bits
  localparam int unsigned SEo  = 0;
  localparam int unsigned SEs  = 1;
  localparam int unsigned SEc  = 2;
  localparam int unsigned SBi  = 3;
  localparam int unsigned SBo  = 4;
  localparam int unsigned SAi  = 5;
  localparam int unsigned SAo  = 6;
  localparam int unsigned SNi  = 7;
  localparam int unsigned SFi  = 8;
  localparam int unsigned SIi  = 9;
  localparam int unsigned SIc  = 10;
  localparam int unsigned SCil = 11;
  localparam int unsigned SCih = 12;
  localparam int unsigned SCol = 13;
  localparam int unsigned SCoh = 14;
  localparam int unsigned SCe  = 15;
  localparam int unsigned SFf  = 16;
  localparam int unsigned SRi  = 17;
  localparam int unsigned SRo  = 18;
  localparam int unsigned SMil = 19;
  localparam int unsigned SMih = 20;
  localparam int unsigned SMz  = 21;
  localparam int unsigned SMc  = 22;
  localparam int unsigned SMe  = 23;

  // flash command bytes and addresses
  localparam logic [14:0] CmdAddr1 = 15'h5555;
  localparam logic [14:0] CmdAddr2 = 15'h2aaa;
  localparam logic [7:0]  CmdAa    = 8'haa;
  localparam logic [7:0]  Cmd55    = 8'h55;
  localparam logic [7:0]  CmdProg  = 8'ha0;
  localparam logic [7:0]  CmdErase = 8'h80;
  localparam logic [7:0]  CmdSect  = 8'h30;
  localparam logic [4:0]  FlagsRst = 5'b11000;

  // flash command states
  localparam logic [2:0] FcIdle  = 3'd0;
  localparam logic [2:0] FcAa    = 3'd1;
  localparam logic [2:0] Fc55    = 3'd2;
  localparam logic [2:0] FcProg  = 3'd3;
  localparam logic [2:0] FcErAa  = 3'd4;
  localparam logic [2:0] FcEr55  = 3'd5;
  localparam logic [2:0] FcErase = 3'd6;

  // controller -> datapath
  typedef struct packed {
    logic       load;     // latch input item
    logic       rd_issue; // issue store reads (ucode)
    logic       rd_mem;   // issue data store read
    logic       execute;  // apply tick / load item
    logic       clr_en;   // ram clear write
    logic       ers_en;   // sector erase write
    logic [15:0] sweep;   // sweep index
  } mcpu_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic start_erase;
  } mcpu_stat_t;

endpackage

// ===== src/mcpu_ctrl.sv =====
// Controller: sequences clear pass, tick phases, erase sweep and output handshake.
module mcpu_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  mcpu_pkg::mcpu_stat_t stat_i,
  output mcpu_pkg::mcpu_cmd_t  cmd_o
);

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StUcode = 3'd2;
  localparam logic [2:0] StMem   = 3'd3;
  localparam logic [2:0] StExec  = 3'd4;
  localparam logic [2:0] StErase = 3'd5;
  localparam logic [2:0] StOut   = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [15:0] cnt_q, cnt_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    cmd_o          = '0;
    cmd_o.sweep    = cnt_q;
    unique case (state_q)
      StClear: begin
        cmd_o.clr_en = 1'b1;
        cnt_d = cnt_q + 16'd1;
        if (cnt_q == 16'hffff) begin
          state_d = StIdle;
          cnt_d = '0;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = StUcode;
        end
      end
      StUcode: begin
        cmd_o.rd_issue = 1'b1;
        state_d = StMem;
      end
      StMem: begin
        cmd_o.rd_mem = 1'b1;
        state_d = StExec;
      end
      StExec: begin
        cmd_o.execute = 1'b1;
        cnt_d = '0;
        state_d = stat_i.start_erase ? StErase : StOut;
      end
      StErase: begin
        cmd_o.ers_en = 1'b1;
        cnt_d = cnt_q + 16'd1;
        if (cnt_q[11:0] == 12'hfff) state_d = StOut;
      end
      StOut: begin
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== src/mcpu_dp.sv =====
// Datapath: stores, registers, ALU, bus and flash command machine.
module mcpu_dp #(
  parameter int unsigned FLASH_BYTES = mcpu_pkg::FlashBytes
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mcpu_pkg::mcpu_cmd_t  cmd_i,
  output mcpu_pkg::mcpu_stat_t stat_o,
  input  logic [2:0]           kind_i,
  input  logic [18:0]          address_i,
  input  logic [23:0]          data_i,
  output logic [7:0]           bus_value_o,
  output logic [15:0]          program_counter_o,
  output logic [15:0]          memory_address_o,
  output logic [7:0]           a_register_o,
  output logic [7:0]           b_register_o,
  output logic [7:0]           bank_register_o,
  output logic [7:0]           instruction_register_o,
  output logic [3:0]           step_count_o,
  output logic [4:0]           flag_lines_o,
  output logic                 serial_send_valid_o
);

  localparam int unsigned FaW = $clog2(FLASH_BYTES);

  logic [23:0] ucode_mem [mcpu_pkg::UcodeDepth];
  logic [7:0]  flash_mem [FLASH_BYTES];
  logic [7:0]  ram_mem   [mcpu_pkg::RamBytes];

  logic [2:0]  kind_q;
  logic [18:0] addr_q;
  logic [23:0] data_q;
  logic [23:0] uword_q;
  logic [7:0]  ram_rd_q, flash_rd_q;

  logic [7:0]  a_q, b_q, bank_q, ir_q, kbd_q, ser_q, bus_q;
  logic [15:0] pc_q, ma_q;
  logic [4:0]  fl_q, live_q;
  logic [3:0]  step_q;
  logic [2:0]  fc_q;
  logic        send_q;
  logic [6:0]  ers_bank_q;

  // flash address of current mem_addr/bank
  logic [18:0] fa_full;
  logic [FaW-1:0] fa;
  assign fa_full = {bank_q[6:0], ma_q[11:0]};
  assign fa      = fa_full[FaW-1:0];

  logic [16:0] uaddr;
  assign uaddr = {fl_q, ir_q, step_q};

  // read issue: microcode first, then data stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) uword_q <= ucode_mem[uaddr] ^ mcpu_pkg::InvMask;
    if (cmd_i.rd_mem) begin
      ram_rd_q   <= ram_mem[ma_q];
      flash_rd_q <= flash_mem[fa];
    end
  end

  // tick combinational
  logic [23:0] m;
  logic [7:0]  cval, bus;
  logic [8:0]  sum;
  logic        ram_sel, is_tick;
  logic        take_ser, take_kbd;
  logic [4:0]  live_t;
  assign is_tick = (kind_q == mcpu_pkg::KindTick);
  assign m       = uword_q;
  assign ram_sel = ma_q[15] | bank_q[7];
  assign cval    = m[mcpu_pkg::SEs] ? ~b_q : b_q;
  assign sum     = {1'b0, a_q} + {1'b0, cval} + {8'd0, m[mcpu_pkg::SEc]};
  assign take_ser = m[mcpu_pkg::SMz] & m[mcpu_pkg::SAi] & ~fl_q[3];
  assign take_kbd = m[mcpu_pkg::SMz] & m[mcpu_pkg::SBi] & ~fl_q[4];

  always_comb begin
    live_t = {live_q[4:3], sum[7], sum[8], sum[7:0] == 8'd0};
    if (take_ser) live_t[3] = 1'b1;
    if (take_kbd) live_t[4] = 1'b1;
    bus = 8'hff;
    if (m[mcpu_pkg::SAo]) bus = a_q;
    if (m[mcpu_pkg::SBo]) bus = b_q;
    if (m[mcpu_pkg::SEo]) bus = sum[7:0];
    else if (m[mcpu_pkg::SEs]) bus = a_q & b_q;
    else if (m[mcpu_pkg::SEc]) bus = a_q | b_q;
    if (m[mcpu_pkg::SRo]) bus = ram_sel ? ram_rd_q : flash_rd_q;
    if (take_ser) bus = ser_q;
    if (take_kbd) bus = kbd_q;
    if (m[mcpu_pkg::SCol]) bus = pc_q[7:0];
    if (m[mcpu_pkg::SCoh]) bus = pc_q[15:8];
  end

  // next PC first; the address register loads from the updated PC
  logic [15:0] pc_next, ma_next;
  always_comb begin
    pc_next = m[mcpu_pkg::SCe] ? pc_q + 16'd1 : pc_q;
    if (m[mcpu_pkg::SCil]) pc_next[7:0] = bus;
    if (m[mcpu_pkg::SCih]) pc_next[15:8] = bus;
    ma_next = m[mcpu_pkg::SMe] ? ma_q + 16'd1 : ma_q;
    if (m[mcpu_pkg::SMil]) ma_next[7:0] = m[mcpu_pkg::SMc] ? pc_next[7:0] : bus;
    if (m[mcpu_pkg::SMih]) begin
      if (m[mcpu_pkg::SMz]) ma_next[15:8] = 8'd0;
      else if (m[mcpu_pkg::SMc]) ma_next[15:8] = pc_next[15:8];
      else ma_next[15:8] = bus;
    end
  end

  // flash command step
  logic [2:0] fc_next;
  logic       fl_prog, fl_erase, fl_wr;
  assign fl_wr = is_tick & m[mcpu_pkg::SRi] & ~ram_sel;
  always_comb begin
    fc_next  = mcpu_pkg::FcIdle;
    fl_prog  = 1'b0;
    fl_erase = 1'b0;
    case (fc_q)
      mcpu_pkg::FcIdle, mcpu_pkg::FcErAa: begin
        if (fa_full[14:0] == mcpu_pkg::CmdAddr1 && bus == mcpu_pkg::CmdAa)
          fc_next = fc_q + 3'd1;
      end
      mcpu_pkg::FcAa, mcpu_pkg::FcEr55: begin
        if (fa_full[14:0] == mcpu_pkg::CmdAddr2 && bus == mcpu_pkg::Cmd55)
          fc_next = fc_q + 3'd1;
      end
      mcpu_pkg::Fc55: begin
        if (fa_full[14:0] == mcpu_pkg::CmdAddr1 && bus == mcpu_pkg::CmdProg)
          fc_next = mcpu_pkg::FcProg;
        else if (fa_full[14:0] == mcpu_pkg::CmdAddr1 && bus == mcpu_pkg::CmdErase)
          fc_next = mcpu_pkg::FcErAa;
      end
      mcpu_pkg::FcProg:  fl_prog = 1'b1;
      mcpu_pkg::FcErase: fl_erase = (bus == mcpu_pkg::CmdSect);
      default: fc_next = mcpu_pkg::FcIdle;
    endcase
  end

  assign stat_o.start_erase = fl_wr & fl_erase;

  // store writes
  logic [18:0] ers_full;
  assign ers_full = {ers_bank_q, cmd_i.sweep[11:0]};
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) ram_mem[cmd_i.sweep] <= 8'h00;
    else if (cmd_i.execute && kind_q == mcpu_pkg::KindRam) ram_mem[addr_q[15:0]] <= data_q[7:0];
    else if (cmd_i.execute && is_tick && m[mcpu_pkg::SRi] && ram_sel) ram_mem[ma_q] <= bus;
    if (cmd_i.execute && kind_q == mcpu_pkg::KindUcode) ucode_mem[addr_q[16:0]] <= data_q;
    if (cmd_i.ers_en) flash_mem[ers_full[FaW-1:0]] <= 8'hff;
    else if (cmd_i.execute && kind_q == mcpu_pkg::KindFlash)
      flash_mem[addr_q[FaW-1:0]] <= data_q[7:0];
    else if (cmd_i.execute && fl_wr && fl_prog) flash_mem[fa] <= flash_rd_q & bus;
  end

  // item latch and erase base
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      addr_q <= address_i;
      data_q <= data_i;
    end
    if (cmd_i.execute) ers_bank_q <= bank_q[6:0];
  end

  // architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0; b_q <= '0; bank_q <= '0; ir_q <= '0; pc_q <= '0; ma_q <= '0;
      fl_q <= '0; live_q <= mcpu_pkg::FlagsRst; step_q <= '0; fc_q <= mcpu_pkg::FcIdle;
      kbd_q <= 8'hff; ser_q <= 8'hff; bus_q <= 8'hff; send_q <= 1'b0;
    end else if (cmd_i.execute) begin
      bus_q  <= 8'hff;
      send_q <= 1'b0;
      case (kind_q)
        mcpu_pkg::KindTick: begin
          bus_q  <= bus;
          send_q <= m[mcpu_pkg::SMz] & m[mcpu_pkg::SAo];
          live_q <= live_t;
          if (take_ser) ser_q <= 8'hff;
          if (take_kbd) kbd_q <= 8'hff;
          if (fl_wr) fc_q <= fc_next;
          if (m[mcpu_pkg::SAi]) a_q <= bus;
          if (m[mcpu_pkg::SBi]) b_q <= bus;
          if (m[mcpu_pkg::SNi]) bank_q <= bus;
          if (m[mcpu_pkg::SFi]) fl_q <= live_t;
          if (m[mcpu_pkg::SIi]) ir_q <= bus;
          pc_q <= pc_next;
          ma_q <= ma_next;
          step_q <= m[mcpu_pkg::SIc] ? 4'd0 : step_q + 4'd1;
        end
        mcpu_pkg::KindPs2: begin
          if (live_q[4]) begin
            kbd_q <= data_q[7:0];
            live_q[4] <= 1'b0;
          end
        end
        mcpu_pkg::KindUart: begin
          if (live_q[3]) begin
            ser_q <= data_q[7:0];
            live_q[3] <= 1'b0;
          end
        end
        mcpu_pkg::KindWarm: begin
          step_q <= '0; pc_q <= '0; ma_q <= '0; bank_q <= '0;
        end
        default: ;
      endcase
    end
  end

  assign bus_value_o            = bus_q;
  assign program_counter_o      = pc_q;
  assign memory_address_o       = ma_q;
  assign a_register_o           = a_q;
  assign b_register_o           = b_q;
  assign bank_register_o        = bank_q;
  assign instruction_register_o = ir_q;
  assign step_count_o           = step_q;
  assign flag_lines_o           = live_q;
  assign serial_send_valid_o    = send_q;

endmodule

// ===== src/microcoded_8bit_cpu_clock_step.sv =====
// Top level: one clock step of a microcoded 8-bit computer per input transfer.
// Each accepted item (tick, store load, PS/2 or UART byte, warm reset) yields one
// result transfer holding the bus value and the machine registers after the item.
// The item is latched at its input transfer; result valid comes once the microcode
// read, the RAM/flash read and the execute step are done. A new item is taken only
// once the result has been taken. A tick that completes a sector erase adds an
// erase pass while the sector is written with 0xFF one byte a cycle. After reset,
// RAM is cleared in a pass over all 65536 bytes before the first input transfer
// is taken. Microcode and flash read as anything until written. The block handles
// one item at a time.
module microcoded_8bit_cpu_clock_step #(
  parameter int unsigned FLASH_BYTES = mcpu_pkg::FlashBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [18:0] address_i,
  input  logic [23:0] data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  bus_value_o,
  output logic [15:0] program_counter_o,
  output logic [15:0] memory_address_o,
  output logic [7:0]  a_register_o,
  output logic [7:0]  b_register_o,
  output logic [7:0]  bank_register_o,
  output logic [7:0]  instruction_register_o,
  output logic [3:0]  step_count_o,
  output logic [4:0]  flag_lines_o,
  output logic        serial_send_valid_o
);

  mcpu_pkg::mcpu_cmd_t  cmd;
  mcpu_pkg::mcpu_stat_t stat;

  mcpu_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  mcpu_dp #(.FLASH_BYTES(FLASH_BYTES)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .kind_i, .address_i, .data_i,
    .bus_value_o, .program_counter_o, .memory_address_o, .a_register_o,
    .b_register_o, .bank_register_o, .instruction_register_o, .step_count_o,
    .flag_lines_o, .serial_send_valid_o
  );

endmodule

// ===== bench/tb.sv =====
// Testbench for the microcoded 8-bit CPU clock step: queued stimulus, inline predictor, checker.
`timescale 1ns / 100ps

module tb;

  // kind 7 is unused by the block; it must leave the machine untouched
  localparam logic [2:0] KindNone = 3'd7;
  localparam int unsigned StallLimit = 300000;
  // minimum number of items queued
  localparam int unsigned RandItems = 1550;

  typedef struct packed {
    logic [2:0]  kind;
    logic [18:0] addr;
    logic [23:0] data;
  } cpu_item_t;

  typedef struct packed {
    logic [7:0]  bus;
    logic [15:0] pc;
    logic [15:0] mar;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  bank;
    logic [7:0]  ir;
    logic [3:0]  step;
    logic [4:0]  flags;
    logic        send;
  } cpu_view_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] kind = '0;
  logic [18:0] address = '0;
  logic [23:0] data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cpu_view_t got;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  microcoded_8bit_cpu_clock_step i_dut (
    .clk_i                  (clk),
    .rst_ni                 (rst_n),
    .in_valid_i             (in_valid),
    .in_ready_o             (in_ready),
    .kind_i                 (kind),
    .address_i              (address),
    .data_i                 (data),
    .out_valid_o            (out_valid),
    .out_ready_i            (out_ready),
    .bus_value_o            (got.bus),
    .program_counter_o      (got.pc),
    .memory_address_o       (got.mar),
    .a_register_o           (got.a),
    .b_register_o           (got.b),
    .bank_register_o        (got.bank),
    .instruction_register_o (got.ir),
    .step_count_o           (got.step),
    .flag_lines_o           (got.flags),
    .serial_send_valid_o    (got.send)
  );

  // ---------------------------------------------------------------------------
  // Shadow machine. The "written" bitmaps keep the stimulus from ever reading
  // microcode or flash that has not been loaded: those read as anything.
  // ---------------------------------------------------------------------------
  logic [23:0] uc_mem [mcpu_pkg::UcodeDepth];
  bit          uc_set [mcpu_pkg::UcodeDepth];
  logic [7:0]  fl_mem [mcpu_pkg::FlashBytes];
  bit          fl_set [mcpu_pkg::FlashBytes];
  logic [7:0]  ram_mem [mcpu_pkg::RamBytes];
  logic [7:0]  sh_a, sh_b, sh_bank, sh_ir, sh_kbd, sh_ser;
  logic [15:0] sh_pc, sh_mar;
  logic [4:0]  sh_latch, sh_live;
  logic [3:0]  sh_step;
  logic [2:0]  sh_fcs;

  cpu_item_t pending_items[$];
  cpu_view_t expected_views[$];
  int unsigned n_errors = 0;

  function automatic logic [16:0] uc_index();
    return {sh_latch, sh_ir, sh_step};
  endfunction

  function automatic logic [18:0] flash_addr();
    return {sh_bank[6:0], sh_mar[11:0]};
  endfunction

  function automatic bit ram_sel();
    return sh_mar[15] || sh_bank[7];
  endfunction

  // JEDEC command sequence on a bus write that targets flash
  function automatic void flash_cmd(input logic [7:0] v);
    logic [18:0] fa;
    logic [14:0] low;
    logic [2:0]  nxt;
    logic [18:0] base;
    fa = flash_addr();
    low = fa[14:0];
    nxt = mcpu_pkg::FcIdle;
    case (sh_fcs)
      mcpu_pkg::FcIdle, mcpu_pkg::FcErAa:
        if (low == mcpu_pkg::CmdAddr1 && v == mcpu_pkg::CmdAa) nxt = sh_fcs + 3'd1;
      mcpu_pkg::FcAa, mcpu_pkg::FcEr55:
        if (low == mcpu_pkg::CmdAddr2 && v == mcpu_pkg::Cmd55) nxt = sh_fcs + 3'd1;
      mcpu_pkg::Fc55: begin
        if (low == mcpu_pkg::CmdAddr1 && v == mcpu_pkg::CmdProg) nxt = mcpu_pkg::FcProg;
        else if (low == mcpu_pkg::CmdAddr1 && v == mcpu_pkg::CmdErase)
          nxt = mcpu_pkg::FcErAa;
      end
      mcpu_pkg::FcProg: fl_mem[fa] = fl_mem[fa] & v;
      mcpu_pkg::FcErase: begin
        if (v == mcpu_pkg::CmdSect) begin
          base = {sh_bank[6:0], 12'h000};
          for (int i = 0; i < mcpu_pkg::SectorBytes; i++) begin
            fl_mem[base | 19'(i)] = 8'hff;
            fl_set[base | 19'(i)] = 1'b1;
          end
        end
      end
      default: ;
    endcase
    sh_fcs = nxt;
  endfunction

  function automatic cpu_view_t clock_step(input cpu_item_t it);
    cpu_view_t   r;
    logic [23:0] m;
    logic [7:0]  cv, bus;
    logic [8:0]  sum;
    bit          send;
    bus = 8'hff;
    send = 1'b0;
    case (it.kind)
      mcpu_pkg::KindTick: begin
        m = uc_mem[uc_index()] ^ mcpu_pkg::InvMask;
        cv = m[mcpu_pkg::SEs] ? ~sh_b : sh_b;
        sum = {1'b0, sh_a} + {1'b0, cv} + {8'd0, m[mcpu_pkg::SEc]};
        sh_live[2:0] = {sum[7], sum[8], sum[7:0] == 8'd0};
        if (m[mcpu_pkg::SAo]) bus = sh_a;
        if (m[mcpu_pkg::SBo]) bus = sh_b;
        if (m[mcpu_pkg::SEo]) bus = sum[7:0];
        else if (m[mcpu_pkg::SEs]) bus = sh_a & sh_b;
        else if (m[mcpu_pkg::SEc]) bus = sh_a | sh_b;
        if (m[mcpu_pkg::SRo]) bus = ram_sel() ? ram_mem[sh_mar] : fl_mem[flash_addr()];
        if (m[mcpu_pkg::SMz]) begin
          // receive registers drain onto the bus while the latched flag says full
          if (m[mcpu_pkg::SAi] && !sh_latch[3]) begin
            bus = sh_ser;
            sh_ser = 8'hff;
            sh_live[3] = 1'b1;
          end
          if (m[mcpu_pkg::SBi] && !sh_latch[4]) begin
            bus = sh_kbd;
            sh_kbd = 8'hff;
            sh_live[4] = 1'b1;
          end
        end
        if (m[mcpu_pkg::SCol]) bus = sh_pc[7:0];
        if (m[mcpu_pkg::SCoh]) bus = sh_pc[15:8];
        if (m[mcpu_pkg::SRi]) begin
          if (ram_sel()) ram_mem[sh_mar] = bus;
          else flash_cmd(bus);
        end
        if (m[mcpu_pkg::SAi]) sh_a = bus;
        if (m[mcpu_pkg::SBi]) sh_b = bus;
        if (m[mcpu_pkg::SNi]) sh_bank = bus;
        if (m[mcpu_pkg::SFi]) sh_latch = sh_live;
        if (m[mcpu_pkg::SIi]) sh_ir = bus;
        if (m[mcpu_pkg::SCe]) sh_pc = sh_pc + 16'd1;
        if (m[mcpu_pkg::SCil]) sh_pc[7:0] = bus;
        if (m[mcpu_pkg::SCih]) sh_pc[15:8] = bus;
        if (m[mcpu_pkg::SMe]) sh_mar = sh_mar + 16'd1;
        if (m[mcpu_pkg::SMil]) sh_mar[7:0] = m[mcpu_pkg::SMc] ? sh_pc[7:0] : bus;
        if (m[mcpu_pkg::SMih]) begin
          if (m[mcpu_pkg::SMz]) sh_mar[15:8] = 8'h00;
          else if (m[mcpu_pkg::SMc]) sh_mar[15:8] = sh_pc[15:8];
          else sh_mar[15:8] = bus;
        end
        send = m[mcpu_pkg::SMz] && m[mcpu_pkg::SAo];
        sh_step = m[mcpu_pkg::SIc] ? 4'd0 : sh_step + 4'd1;
      end
      mcpu_pkg::KindUcode: begin
        uc_mem[it.addr[16:0]] = it.data;
        uc_set[it.addr[16:0]] = 1'b1;
      end
      mcpu_pkg::KindFlash: begin
        fl_mem[19'(it.addr % mcpu_pkg::FlashBytes)] = it.data[7:0];
        fl_set[19'(it.addr % mcpu_pkg::FlashBytes)] = 1'b1;
      end
      mcpu_pkg::KindRam: ram_mem[it.addr[15:0]] = it.data[7:0];
      mcpu_pkg::KindPs2: begin
        if (sh_live[4]) begin
          sh_kbd = it.data[7:0];
          sh_live[4] = 1'b0;
        end
      end
      mcpu_pkg::KindUart: begin
        if (sh_live[3]) begin
          sh_ser = it.data[7:0];
          sh_live[3] = 1'b0;
        end
      end
      mcpu_pkg::KindWarm: begin
        sh_step = '0;
        sh_pc = '0;
        sh_mar = '0;
        sh_bank = '0;
      end
      default: ;
    endcase
    r.bus = bus;
    r.pc = sh_pc;
    r.mar = sh_mar;
    r.a = sh_a;
    r.b = sh_b;
    r.bank = sh_bank;
    r.ir = sh_ir;
    r.step = sh_step;
    r.flags = sh_live;
    r.send = send;
    return r;
  endfunction

  task automatic queue_item(input logic [2:0] k, input logic [18:0] ad, input logic [23:0] dt);
    cpu_item_t it;
    it.kind = k;
    it.addr = ad;
    it.data = dt;
    pending_items.push_back(it);
    expected_views.push_back(clock_step(it));
  endtask

  // A tick, preceded by whatever loads keep it off unwritten entries.
  task automatic queue_tick();
    logic [23:0] m;
    logic [18:0] fa;
    if (!uc_set[uc_index()])
      queue_item(mcpu_pkg::KindUcode, {2'($urandom), uc_index()}, 24'($urandom));
    m = uc_mem[uc_index()] ^ mcpu_pkg::InvMask;
    fa = flash_addr();
    if (!ram_sel() && !fl_set[fa] &&
        (m[mcpu_pkg::SRo] || (m[mcpu_pkg::SRi] && sh_fcs == mcpu_pkg::FcProg)))
      queue_item(mcpu_pkg::KindFlash, fa, 24'($urandom));
    queue_item(mcpu_pkg::KindTick, 19'($urandom), 24'($urandom));
  endtask

  // Tick with a chosen active-high control word at the current step.
  task automatic tick_word(input logic [23:0] m);
    queue_item(mcpu_pkg::KindUcode, {2'($urandom), uc_index()}, m ^ mcpu_pkg::InvMask);
    queue_tick();
  endtask

  // Get a byte into B via the keyboard register, then put B on the bus with extra controls.
  task automatic bus_write(input logic [7:0] v, input logic [23:0] extra);
    queue_item(mcpu_pkg::KindPs2, 19'($urandom), {16'($urandom), v});
    tick_word(24'(1) << mcpu_pkg::SFi);
    tick_word((24'(1) << mcpu_pkg::SMz) | (24'(1) << mcpu_pkg::SBi));
    tick_word((24'(1) << mcpu_pkg::SBo) | extra);
  endtask

  task automatic point_at(input logic [7:0] bk, input logic [15:0] ad);
    bus_write(bk, 24'(1) << mcpu_pkg::SNi);
    bus_write(ad[7:0], 24'(1) << mcpu_pkg::SMil);
    bus_write(ad[15:8], 24'(1) << mcpu_pkg::SMih);
  endtask

  task automatic flash_store_byte(input logic [7:0] bk, input logic [15:0] ad,
                                  input logic [7:0] v);
    point_at(bk, ad);
    bus_write(v, 24'(1) << mcpu_pkg::SRi);
  endtask

  // unlock prefix: 0xAA to 0x5555, 0x55 to 0x2AAA
  task automatic flash_unlock();
    flash_store_byte(8'h05, 16'h0555, mcpu_pkg::CmdAa);
    flash_store_byte(8'h02, 16'h0aaa, mcpu_pkg::Cmd55);
  endtask

  task automatic flash_program(input logic [7:0] bk, input logic [15:0] ad, input logic [7:0] v);
    flash_unlock();
    flash_store_byte(8'h05, 16'h0555, mcpu_pkg::CmdProg);
    flash_store_byte(bk, ad, v);
    tick_word((24'(1) << mcpu_pkg::SRo) | (24'(1) << mcpu_pkg::SAi));
  endtask

  task automatic flash_erase(input logic [7:0] bk);
    flash_unlock();
    flash_store_byte(8'h05, 16'h0555, mcpu_pkg::CmdErase);
    flash_unlock();
    flash_store_byte(bk, {4'h0, 12'($urandom)}, mcpu_pkg::CmdSect);
    tick_word((24'(1) << mcpu_pkg::SRo) | (24'(1) << mcpu_pkg::SAi));
  endtask

  task automatic build_stimulus();
    int unsigned pick;
    sh_a = '0; sh_b = '0; sh_pc = '0; sh_mar = '0; sh_bank = '0;
    sh_latch = '0; sh_live = mcpu_pkg::FlagsRst; sh_ir = '0; sh_step = '0;
    sh_kbd = 8'hff; sh_ser = 8'hff; sh_fcs = mcpu_pkg::FcIdle;
    for (int i = 0; i < mcpu_pkg::RamBytes; i++) ram_mem[i] = 8'h00;

    // directed: field extremes, every kind, flash program and erase, RAM path
    queue_item(mcpu_pkg::KindUcode, 19'h7ffff, 24'hffffff);
    queue_item(mcpu_pkg::KindFlash, 19'h7ffff, 24'hffffff);
    queue_item(mcpu_pkg::KindRam, 19'h7ffff, 24'hffffff);
    queue_item(mcpu_pkg::KindFlash, 19'h00000, 24'h000000);
    queue_item(mcpu_pkg::KindRam, 19'h00000, 24'h000000);
    queue_item(KindNone, 19'h7ffff, 24'hffffff);
    tick_word(24'h000000);
    tick_word(24'hffffff);
    queue_item(mcpu_pkg::KindUart, '0, 24'h0000a5);
    queue_item(mcpu_pkg::KindUart, '0, 24'h00005a);  // dropped: register still full
    queue_item(mcpu_pkg::KindPs2, '0, 24'hffff3c);
    queue_item(mcpu_pkg::KindPs2, '0, 24'h0000c3);   // dropped
    tick_word(24'(1) << mcpu_pkg::SFi);
    tick_word((24'(1) << mcpu_pkg::SMz) | (24'(1) << mcpu_pkg::SAi) |
              (24'(1) << mcpu_pkg::SAo));
    queue_item(mcpu_pkg::KindWarm, '0, '0);
    flash_program(8'h10, 16'h0123, 8'h5a);
    flash_erase(8'h10);
    flash_store_byte(8'h07, 16'h0000, 8'h11);      // command state 7 never reached; stray write
    point_at(8'h80, 16'h1234);
    bus_write(8'h9c, 24'(1) << mcpu_pkg::SRi);
    tick_word((24'(1) << mcpu_pkg::SRo) | (24'(1) << mcpu_pkg::SAi));

    // random: mostly ticks over random microcode, mixed with loads and bytes
    while (pending_items.size() < RandItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) queue_tick();
      else if (pick < 63) queue_item(mcpu_pkg::KindUcode, 19'($urandom), 24'($urandom));
      else if (pick < 69) queue_item(mcpu_pkg::KindFlash, 19'($urandom), 24'($urandom));
      else if (pick < 75) queue_item(mcpu_pkg::KindRam, 19'($urandom), 24'($urandom));
      else if (pick < 82) queue_item(mcpu_pkg::KindPs2, 19'($urandom), 24'($urandom));
      else if (pick < 89) queue_item(mcpu_pkg::KindUart, 19'($urandom), 24'($urandom));
      else if (pick < 93) queue_item(mcpu_pkg::KindWarm, 19'($urandom), 24'($urandom));
      else if (pick < 95) queue_item(KindNone, 19'($urandom), 24'($urandom));
      else if (pick < 97) bus_write(8'($urandom), 24'($urandom) & 24'h3e0f80);
      else if (pick < 99) flash_program({4'h0, 4'($urandom)}, 16'($urandom), 8'($urandom));
      else if ($urandom_range(0, 3) == 0) flash_erase({4'h0, 4'($urandom)});
      else queue_tick();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one transfer per handshake; random gaps except in a quiet stretch
  // placed after the RAM clear pass.
  // ---------------------------------------------------------------------------
  int unsigned drv_cycle = 0;
  cpu_item_t next_item;

  always @(posedge clk) begin
    drv_cycle <= drv_cycle + 1;
    if (rst_n && (!in_valid || in_ready)) begin
      if (pending_items.size() != 0 &&
          ((drv_cycle > 66000 && drv_cycle < 69000) || $urandom_range(0, 99) >= 9)) begin
        next_item = pending_items.pop_front();
        kind <= next_item.kind;
        address <= next_item.addr;
        data <= next_item.data;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transfer against the oldest expected view.
  // The receiver goes deaf once so the input side backs up.
  // ---------------------------------------------------------------------------
  int unsigned mon_cycle = 0;
  cpu_view_t want;

  always @(posedge clk) begin
    mon_cycle <= mon_cycle + 1;
    if (mon_cycle >= 70000 && mon_cycle < 70600) out_ready <= 1'b0;
    else if (mon_cycle > 66000 && mon_cycle < 69000) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 99) >= 9);
    if (out_valid && out_ready) begin
      if (expected_views.size() == 0) begin
        $error("unexpected result transfer");
        n_errors++;
      end else begin
        want = expected_views.pop_front();
        if (got.bus !== want.bus) begin
          $error("bus_value: expected %h, got %h", want.bus, got.bus); n_errors++;
        end
        if (got.pc !== want.pc) begin
          $error("program_counter: expected %h, got %h", want.pc, got.pc); n_errors++;
        end
        if (got.mar !== want.mar) begin
          $error("memory_address: expected %h, got %h", want.mar, got.mar); n_errors++;
        end
        if (got.a !== want.a) begin
          $error("a_register: expected %h, got %h", want.a, got.a); n_errors++;
        end
        if (got.b !== want.b) begin
          $error("b_register: expected %h, got %h", want.b, got.b); n_errors++;
        end
        if (got.bank !== want.bank) begin
          $error("bank_register: expected %h, got %h", want.bank, got.bank); n_errors++;
        end
        if (got.ir !== want.ir) begin
          $error("instruction_register: expected %h, got %h", want.ir, got.ir); n_errors++;
        end
        if (got.step !== want.step) begin
          $error("step_count: expected %h, got %h", want.step, got.step); n_errors++;
        end
        if (got.flags !== want.flags) begin
          $error("flag_lines: expected %h, got %h", want.flags, got.flags); n_errors++;
        end
        if (got.send !== want.send) begin
          $error("serial_send_valid: expected %h, got %h", want.send, got.send); n_errors++;
        end
      end
    end
  end

  // Watchdog: cycles without any transfer; covers the RAM clear pass and a sector erase.
  int unsigned idle_run = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (idle_run >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() == 0);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    while (expected_views.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (out_valid) begin
      $error("result transfer offered with nothing expected");
      n_errors++;
    end
    if (n_errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
src/mcpu_pkg.sv
src/mcpu_ctrl.sv
src/mcpu_dp.sv
src/microcoded_8bit_cpu_clock_step.sv
bench/tb.sv
